// File: src/pmq_pkg.sv
// Shared types and constants for the priority message queue.
// Used by pmq_cell, pmq_chain and priority_message_queue_top; depends on nothing.
package pmq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int HANDLE_BITS_DEF = 16;

	// Field widths of the stream items
	localparam int MODE_W   = 3;
	localparam int HANDLE_W = 16;
	localparam int TYPE_W   = 5;
	localparam int PRIO_W   = 8;
	localparam int SIZE_W   = 24;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;
	localparam int BYTES_W  = 32;
	localparam int CFG_W    = 5;
	localparam int IN_W     = 56;
	localparam int OUT_W    = 72;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Entry layout inside a cell, lowest bits first: size, priority, type, handle
	localparam int SIZE_LSB   = 0;
	localparam int PRIO_LSB   = SIZE_LSB + SIZE_W;
	localparam int TYPE_LSB   = PRIO_LSB + PRIO_W;
	localparam int HANDLE_LSB = TYPE_LSB + TYPE_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT        = 3'd0,
		MODE_GET        = 3'd1,
		MODE_FLUSH_TYPE = 3'd2,
		MODE_FLUSH_ALL  = 3'd3,
		MODE_COUNT      = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_NOT_READY = 3'd1,
		STAT_NOT_INIT  = 3'd2,
		STAT_ABORTED   = 3'd3,
		STAT_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_ENABLE    = 2'd0,
		REG_ABORT     = 2'd1,
		REG_CACHING   = 2'd2,
		REG_DATA_TYPE = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CMD_HOLD    = 3'd0,
		CMD_PUT     = 3'd1,
		CMD_POP     = 3'd2,
		CMD_MARK    = 3'd3,
		CMD_COMPACT = 3'd4,
		CMD_CLEAR   = 3'd5
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t             cmd;
		logic [TYPE_W-1:0]     key_type;
		logic [PRIO_W-1:0]     key_prio;
	} cell_ctrl_t;

endpackage

// File: src/pmq_cell.sv
// One slot of the sorted queue chain: an entry and its occupied flag.
// Depends on pmq_pkg for the command codes and the entry layout.
module pmq_cell #(
	parameter int HANDLE_BITS = pmq_pkg::HANDLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pmq_pkg::cell_ctrl_t     ctrl,
	input  logic [HANDLE_BITS+pmq_pkg::HANDLE_LSB-1:0] new_entry,
	input  logic [HANDLE_BITS+pmq_pkg::HANDLE_LSB-1:0] left_entry,
	input  logic                    left_valid,
	input  logic                    left_keep,
	input  logic [HANDLE_BITS+pmq_pkg::HANDLE_LSB-1:0] right_entry,
	input  logic                    right_valid,
	output logic [HANDLE_BITS+pmq_pkg::HANDLE_LSB-1:0] entry,
	output logic                    valid,
	output logic                    keep,
	output logic                    match
);

	localparam int ENTRY_W = HANDLE_BITS + pmq_pkg::HANDLE_LSB;

	logic [ENTRY_W-1:0]             entry_q;
	logic                           valid_q;
	logic [ENTRY_W-1:0]             entry_nxt;
	logic                           valid_nxt;
	logic [pmq_pkg::PRIO_W-1:0]     cur_prio;
	logic [pmq_pkg::TYPE_W-1:0]     cur_type;

	assign cur_prio = entry_q[pmq_pkg::PRIO_LSB +: pmq_pkg::PRIO_W];
	assign cur_type = entry_q[pmq_pkg::TYPE_LSB +: pmq_pkg::TYPE_W];

	// An entry stays in place on insertion when it ranks at or above the new one
	assign keep  = valid_q && (cur_prio >= ctrl.key_prio);
	assign match = valid_q && (cur_type == ctrl.key_type);

	assign entry = entry_q;
	assign valid = valid_q;

	always_comb begin
		entry_nxt = entry_q;
		valid_nxt = valid_q;
		unique case (ctrl.cmd)
			pmq_pkg::CMD_HOLD: begin
			end
			pmq_pkg::CMD_PUT: begin
				if (!keep) begin
					if (left_keep) begin
						entry_nxt = new_entry;
						valid_nxt = 1'b1;
					end else begin
						entry_nxt = left_entry;
						valid_nxt = left_valid;
					end
				end
			end
			pmq_pkg::CMD_POP: begin
				entry_nxt = right_entry;
				valid_nxt = right_valid;
			end
			pmq_pkg::CMD_MARK: begin
				valid_nxt = valid_q && !match;
			end
			pmq_pkg::CMD_COMPACT: begin
				// pull a live entry into a hole; the hole moves one slot toward the tail
				if (!valid_q && right_valid) begin
					entry_nxt = right_entry;
					valid_nxt = 1'b1;
				end else if (valid_q && !left_valid) begin
					valid_nxt = 1'b0;
				end
			end
			pmq_pkg::CMD_CLEAR: begin
				valid_nxt = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

endmodule

// File: src/pmq_chain.sv
// Row of pmq_cell slots kept in descending priority order, head at slot 0.
// Depends on pmq_pkg and pmq_cell.
module pmq_chain #(
	parameter int QUEUE_DEPTH = pmq_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = pmq_pkg::HANDLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pmq_pkg::cell_ctrl_t     ctrl,
	input  logic [HANDLE_BITS+pmq_pkg::HANDLE_LSB-1:0] new_entry,
	output logic [HANDLE_BITS+pmq_pkg::HANDLE_LSB-1:0] head_entry,
	output logic                    head_valid,
	output logic                    full,
	output logic [QUEUE_DEPTH-1:0]  match_bits
);

	localparam int ENTRY_W = HANDLE_BITS + pmq_pkg::HANDLE_LSB;

	logic [ENTRY_W-1:0]     entries [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valids;
	logic [QUEUE_DEPTH-1:0] keeps;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ENTRY_W-1:0] left_entry;
		logic               left_valid;
		logic               left_keep;
		logic [ENTRY_W-1:0] right_entry;
		logic               right_valid;

		if (i == 0) begin : g_head
			// the head behaves as if a full, higher-ranking slot sat before it
			assign left_entry = '0;
			assign left_valid = 1'b1;
			assign left_keep  = 1'b1;
		end else begin : g_mid
			assign left_entry = entries[i-1];
			assign left_valid = valids[i-1];
			assign left_keep  = keeps[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = '0;
			assign right_valid = 1'b0;
		end else begin : g_body
			assign right_entry = entries[i+1];
			assign right_valid = valids[i+1];
		end

		pmq_cell #(
			.HANDLE_BITS (HANDLE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.left_valid  (left_valid),
			.left_keep   (left_keep),
			.right_entry (right_entry),
			.right_valid (right_valid),
			.entry       (entries[i]),
			.valid       (valids[i]),
			.keep        (keeps[i]),
			.match       (match_bits[i])
		);
	end

	assign head_entry = entries[0];
	assign head_valid = valids[0];
	assign full       = valids[QUEUE_DEPTH-1];

endmodule

// File: src/priority_message_queue_top.sv
// Priority message queue: a bounded queue of message entries, highest priority and oldest
// first. An accepted beat is captured, then executed from the EXEC state; put, get, flush-all
// and rejected operations complete there once the output is free. Flush by type marks matching
// entries and then squeezes the holes out of the cell chain, one slot per cycle. Count shifts
// the per-slot match flags out one per cycle. The next beat is taken as soon as the control
// returns to idle; a result waiting on m_tready delays only the completion of the following
// operation. No clearing pass follows reset.
// Depends on pmq_pkg and pmq_chain.
module priority_message_queue_top #(
	parameter int QUEUE_DEPTH = pmq_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = pmq_pkg::HANDLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [pmq_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// mode[2:0], msg_handle[18:3], msg_type[23:19], priority_req[31:24], packet_size[55:32]
	input  logic [pmq_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[2:0], out_handle[18:3], out_type[23:19], out_priority[31:24],
	// match_count[38:32], data_bytes[70:39], emptied[71]
	output logic [pmq_pkg::OUT_W-1:0]    m_tdata
);

	localparam int ENTRY_W = HANDLE_BITS + pmq_pkg::HANDLE_LSB;
	localparam int HB_KEEP = (HANDLE_BITS < pmq_pkg::HANDLE_W) ? HANDLE_BITS : pmq_pkg::HANDLE_W;
	localparam int CCW     = $clog2(2 * QUEUE_DEPTH + 1);
	localparam int SCW     = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_COMPACT,
		ST_COUNT
	} state_t;

	state_t                          state_q, state_nxt;

	// configuration
	logic                            en_q;
	logic                            abort_q;
	logic                            caching_q;
	logic [pmq_pkg::TYPE_W-1:0]      dtc_q;

	// captured input beat
	logic [pmq_pkg::MODE_W-1:0]      mode_q;
	logic [pmq_pkg::HANDLE_W-1:0]    handle_q;
	logic [pmq_pkg::TYPE_W-1:0]      type_q;
	logic [pmq_pkg::PRIO_W-1:0]      prio_q;
	logic [pmq_pkg::SIZE_W-1:0]      size_q;

	logic [pmq_pkg::BYTES_W-1:0]     byte_total_q, bytes_nxt;
	logic                            emptied_q, emptied_nxt;

	logic [CCW-1:0]                  compact_cnt_q;
	logic [SCW-1:0]                  scan_cnt_q;
	logic [QUEUE_DEPTH-1:0]          match_sr_q;
	logic [pmq_pkg::COUNT_W-1:0]     acc_q;

	logic                            m_tvalid_q;
	logic [pmq_pkg::OUT_W-1:0]       m_tdata_q;

	// chain interface
	pmq_pkg::cell_ctrl_t             ctrl;
	logic [ENTRY_W-1:0]              new_entry;
	logic [ENTRY_W-1:0]              head_entry;
	logic                            head_valid;
	logic                            full;
	logic [QUEUE_DEPTH-1:0]          match_bits;

	logic [pmq_pkg::PRIO_W-1:0]      head_prio;
	logic [pmq_pkg::TYPE_W-1:0]      head_type;
	logic [pmq_pkg::SIZE_W-1:0]      head_size;
	logic [HANDLE_BITS-1:0]          head_handle;
	logic [pmq_pkg::BYTES_W-1:0]     get_total;
	logic                            get_ok;
	logic                            out_free;

	// result of the operation that completes this cycle
	logic                            res_load;
	pmq_pkg::status_t                res_status;
	logic [pmq_pkg::HANDLE_W-1:0]    res_handle;
	logic [pmq_pkg::TYPE_W-1:0]      res_type;
	logic [pmq_pkg::PRIO_W-1:0]      res_prio;
	logic [pmq_pkg::COUNT_W-1:0]     res_count;
	logic                            compact_load;
	logic                            scan_load;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign head_prio   = head_entry[pmq_pkg::PRIO_LSB +: pmq_pkg::PRIO_W];
	assign head_type   = head_entry[pmq_pkg::TYPE_LSB +: pmq_pkg::TYPE_W];
	assign head_size   = head_entry[pmq_pkg::SIZE_LSB +: pmq_pkg::SIZE_W];
	assign head_handle = head_entry[pmq_pkg::HANDLE_LSB +: HANDLE_BITS];
	assign get_total   = byte_total_q - pmq_pkg::BYTES_W'(head_size);
	assign get_ok      = en_q && !abort_q && !caching_q && head_valid && (head_prio >= prio_q);

	assign new_entry = {HANDLE_BITS'(handle_q[HB_KEEP-1:0]), type_q, prio_q, size_q};

	always_comb begin
		state_nxt    = state_q;
		ctrl.cmd     = pmq_pkg::CMD_HOLD;
		ctrl.key_type = type_q;
		ctrl.key_prio = prio_q;
		res_load     = 1'b0;
		res_status   = pmq_pkg::STAT_OK;
		res_handle   = '0;
		res_type     = '0;
		res_prio     = '0;
		res_count    = '0;
		bytes_nxt    = byte_total_q;
		emptied_nxt  = emptied_q;
		compact_load = 1'b0;
		scan_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (mode_q)
					pmq_pkg::MODE_PUT: begin
						if (out_free) begin
							res_load  = 1'b1;
							state_nxt = ST_IDLE;
							if (!en_q) begin
								res_status = pmq_pkg::STAT_NOT_INIT;
							end else if (full) begin
								res_status = pmq_pkg::STAT_FULL;
							end else begin
								ctrl.cmd = pmq_pkg::CMD_PUT;
								if (type_q == dtc_q) begin
									bytes_nxt = byte_total_q + pmq_pkg::BYTES_W'(size_q);
								end
							end
						end
					end
					pmq_pkg::MODE_GET: begin
						if (out_free) begin
							res_load  = 1'b1;
							state_nxt = ST_IDLE;
							priority if (!en_q) begin
								res_status = pmq_pkg::STAT_NOT_INIT;
							end else if (abort_q) begin
								res_status = pmq_pkg::STAT_ABORTED;
							end else if (!get_ok) begin
								res_status = pmq_pkg::STAT_NOT_READY;
							end else begin
								ctrl.cmd   = pmq_pkg::CMD_POP;
								res_handle = pmq_pkg::HANDLE_W'(head_handle[HB_KEEP-1:0]);
								res_type   = head_type;
								res_prio   = head_prio;
								if (head_type == dtc_q) begin
									bytes_nxt   = get_total;
									emptied_nxt = (get_total == '0);
								end
							end
						end
					end
					pmq_pkg::MODE_FLUSH_TYPE: begin
						// drop matching entries now, squeeze out the holes afterwards
						ctrl.cmd     = pmq_pkg::CMD_MARK;
						compact_load = 1'b1;
						state_nxt    = ST_COMPACT;
						if (type_q == dtc_q) begin
							bytes_nxt   = '0;
							emptied_nxt = 1'b1;
						end
					end
					pmq_pkg::MODE_FLUSH_ALL: begin
						if (out_free) begin
							ctrl.cmd    = pmq_pkg::CMD_CLEAR;
							bytes_nxt   = '0;
							emptied_nxt = 1'b1;
							res_load    = 1'b1;
							state_nxt   = ST_IDLE;
						end
					end
					pmq_pkg::MODE_COUNT: begin
						if (en_q) begin
							scan_load = 1'b1;
							state_nxt = ST_COUNT;
						end else if (out_free) begin
							res_status = pmq_pkg::STAT_NOT_INIT;
							res_load   = 1'b1;
							state_nxt  = ST_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							res_load  = 1'b1;
							state_nxt = ST_IDLE;
						end
					end
				endcase
			end
			ST_COMPACT: begin
				if (compact_cnt_q != '0) begin
					ctrl.cmd = pmq_pkg::CMD_COMPACT;
				end else if (out_free) begin
					res_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_COUNT: begin
				if (scan_cnt_q == '0 && out_free) begin
					res_count = acc_q;
					res_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			en_q          <= 1'b0;
			abort_q       <= 1'b0;
			caching_q     <= 1'b0;
			dtc_q         <= pmq_pkg::TYPE_W'(1);
			mode_q        <= '0;
			handle_q      <= '0;
			type_q        <= '0;
			prio_q        <= '0;
			size_q        <= '0;
			byte_total_q  <= '0;
			emptied_q     <= 1'b1;
			compact_cnt_q <= '0;
			scan_cnt_q    <= '0;
			match_sr_q    <= '0;
			acc_q         <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			state_q      <= state_nxt;
			byte_total_q <= bytes_nxt;
			emptied_q    <= emptied_nxt;

			if (cfg_wr_en) begin
				unique case (pmq_pkg::cfg_reg_t'(cfg_index))
					pmq_pkg::REG_ENABLE:    en_q      <= cfg_data[0];
					pmq_pkg::REG_ABORT:     abort_q   <= cfg_data[0];
					pmq_pkg::REG_CACHING:   caching_q <= cfg_data[0];
					pmq_pkg::REG_DATA_TYPE: dtc_q     <= cfg_data;
				endcase
			end

			if (s_tvalid && s_tready) begin
				mode_q   <= s_tdata[2:0];
				handle_q <= s_tdata[18:3];
				type_q   <= s_tdata[23:19];
				prio_q   <= s_tdata[31:24];
				size_q   <= s_tdata[55:32];
			end

			if (compact_load) begin
				compact_cnt_q <= CCW'(2 * QUEUE_DEPTH);
			end else if (state_q == ST_COMPACT && compact_cnt_q != '0) begin
				compact_cnt_q <= compact_cnt_q - CCW'(1);
			end

			// shift the match flags out of the head end, one slot per cycle
			if (scan_load) begin
				match_sr_q <= match_bits;
				scan_cnt_q <= SCW'(QUEUE_DEPTH);
				acc_q      <= '0;
			end else if (state_q == ST_COUNT && scan_cnt_q != '0) begin
				match_sr_q <= match_sr_q >> 1;
				scan_cnt_q <= scan_cnt_q - SCW'(1);
				if (acc_q != pmq_pkg::COUNT_MAX) begin
					acc_q <= acc_q + pmq_pkg::COUNT_W'(match_sr_q[0]);
				end
			end

			if (res_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {emptied_nxt, bytes_nxt, res_count, res_prio, res_type,
					res_handle, res_status};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	pmq_chain #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.new_entry  (new_entry),
		.head_entry (head_entry),
		.head_valid (head_valid),
		.full       (full),
		.match_bits (match_bits)
	);

endmodule
